FILE: hdl/rrca_pkg.sv
package rrca_pkg;

  localparam int unsigned SEQ_W = 32;
  localparam int unsigned LEN_W = 16;

  // Result kinds.
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [LEN_W-1:0] len_t;

endpackage

FILE: hdl/reorder_receiver_cumulative_ack_core.sv
// Each accepted segment is classified first. An ignored one (after FIN, or with the ACK bit set)
// frees the input with no result; a handshake, out-of-window, FIN or empty one is acknowledged;
// an early one is looked up in every cache slot and stored, then acknowledged; an in-order one is
// delivered, then each next match found by a cache walk is delivered, then it is acknowledged.
// The acknowledgement is registered as the input frees; one segment is in flight at a time.
// Synchronous active-low reset clears the connection state, our_seq and the slot valid bits.
module reorder_receiver_cumulative_ack_core #(
  parameter int unsigned CACHE_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  rrca_pkg::seq_t       cfg_data,
  // segment input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rrca_pkg::seq_t       in_seg_seq,
  input  rrca_pkg::len_t       in_seg_len,
  input  rrca_pkg::seq_t       in_seg_window,
  input  logic                 in_syn_bit,
  input  logic                 in_fin_bit,
  input  logic                 in_data_bit,
  input  logic                 in_ack_bit,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output rrca_pkg::seq_t       out_seq,
  output rrca_pkg::len_t       out_len,
  output rrca_pkg::seq_t       out_ack_number,
  output logic                 out_syn_out,
  output logic                 out_fin_out,
  output logic                 out_dup_flag,
  output logic                 out_overflow_flag,
  output logic                 out_last
);

  localparam int unsigned IdxW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CACHE_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASS,
    ST_SCAN,
    ST_STORE,
    ST_DELIV,
    ST_DRAIN,
    ST_ACK
  } state_t;

  state_t              state_r;
  logic                connected_r;
  logic                done_r;
  rrca_pkg::seq_t      next_exp_r;
  rrca_pkg::seq_t      our_seq_r;
  rrca_pkg::seq_t      window_r;

  rrca_pkg::seq_t      seg_seq_r;
  rrca_pkg::len_t      seg_len_r;
  rrca_pkg::seq_t      seg_win_r;
  logic                seg_fin_r;
  logic                seg_data_r;
  logic                seg_ack_r;
  logic                syn_r;
  logic                dup_r;
  logic                ovf_r;

  logic [IdxW-1:0]     idx_r;
  logic                hit_found_r;
  logic [IdxW-1:0]     hit_idx_r;
  logic                free_found_r;
  logic [IdxW-1:0]     free_idx_r;
  rrca_pkg::seq_t      del_seq_r;
  rrca_pkg::len_t      del_len_r;

  logic [CACHE_SLOTS-1:0] slot_valid_r;
  rrca_pkg::seq_t      slot_seq_r [CACHE_SLOTS];
  rrca_pkg::len_t      slot_len_r [CACHE_SLOTS];

  logic                out_valid_r;
  logic                out_kind_r;
  rrca_pkg::seq_t      out_seq_r;
  rrca_pkg::len_t      out_len_r;
  rrca_pkg::seq_t      out_ack_r;
  logic                out_syn_r;
  logic                out_fin_r;
  logic                out_dup_r;
  logic                out_ovf_r;
  logic                out_last_r;

  logic                in_beat;
  logic                out_free;
  logic                out_load;
  rrca_pkg::seq_t      cmp_key;
  logic                cmp_hit;
  logic                out_of_window;

  assign in_stall = (state_r != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free && ((state_r == ST_DELIV) || (state_r == ST_ACK));

  // The one comparator is shared by the cache lookup and the drain search.
  assign cmp_key = (state_r == ST_SCAN) ? seg_seq_r : next_exp_r;
  assign cmp_hit = slot_valid_r[idx_r] && (slot_seq_r[idx_r] == cmp_key);

  assign out_of_window = (seg_seq_r - next_exp_r) > window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      connected_r  <= 1'b0;
      done_r       <= 1'b0;
      next_exp_r   <= '0;
      our_seq_r    <= '0;
      window_r     <= '0;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready && !connected_r) begin
        our_seq_r <= cfg_data;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            seg_seq_r  <= in_seg_seq;
            seg_len_r  <= in_seg_len;
            seg_win_r  <= in_seg_window;
            seg_fin_r  <= in_fin_bit;
            seg_data_r <= in_data_bit;
            seg_ack_r  <= in_ack_bit;
            syn_r      <= 1'b0;
            dup_r      <= 1'b0;
            ovf_r      <= 1'b0;
            state_r    <= ST_CLASS;
          end
        end

        ST_CLASS: begin
          if (!connected_r) begin
            connected_r <= 1'b1;
            next_exp_r  <= seg_seq_r + rrca_pkg::SEQ_W'(1);
            window_r    <= seg_win_r;
            syn_r       <= 1'b1;
            state_r     <= ST_ACK;
          end else if (done_r || seg_ack_r) begin
            state_r <= ST_IDLE;
          end else if (out_of_window) begin
            dup_r   <= 1'b1;
            state_r <= ST_ACK;
          end else if (seg_seq_r != next_exp_r) begin
            idx_r        <= '0;
            hit_found_r  <= 1'b0;
            free_found_r <= 1'b0;
            state_r      <= ST_SCAN;
          end else if (seg_data_r) begin
            del_seq_r <= seg_seq_r;
            del_len_r <= seg_len_r;
            state_r   <= ST_DELIV;
          end else if (seg_fin_r) begin
            done_r     <= 1'b1;
            our_seq_r  <= our_seq_r + rrca_pkg::SEQ_W'(1);
            next_exp_r <= next_exp_r + rrca_pkg::SEQ_W'(1);
            state_r    <= ST_ACK;
          end else begin
            state_r <= ST_ACK;
          end
        end

        // Look for a slot holding this sequence number and for the lowest free slot.
        ST_SCAN: begin
          if (cmp_hit && !hit_found_r) begin
            hit_found_r <= 1'b1;
            hit_idx_r   <= idx_r;
          end
          if (!slot_valid_r[idx_r] && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= idx_r;
          end
          if (idx_r == LastIdx) begin
            state_r <= ST_STORE;
          end else begin
            idx_r <= idx_r + IdxW'(1);
          end
        end

        ST_STORE: begin
          if (hit_found_r) begin
            dup_r <= 1'b1;
          end else if (free_found_r) begin
            slot_valid_r[free_idx_r] <= 1'b1;
          end else begin
            ovf_r <= 1'b1;
          end
          state_r <= ST_ACK;
        end

        ST_DELIV: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= rrca_pkg::KIND_DELIVER;
            out_seq_r   <= del_seq_r;
            out_len_r   <= del_len_r;
            out_ack_r   <= '0;
            out_syn_r   <= 1'b0;
            out_fin_r   <= 1'b0;
            out_dup_r   <= 1'b0;
            out_ovf_r   <= 1'b0;
            out_last_r  <= 1'b0;
            next_exp_r  <= next_exp_r + rrca_pkg::SEQ_W'(del_len_r);
            idx_r       <= '0;
            state_r     <= ST_DRAIN;
          end
        end

        // Walk from slot zero so that the lowest matching slot drains first.
        ST_DRAIN: begin
          if (cmp_hit) begin
            del_seq_r           <= slot_seq_r[idx_r];
            del_len_r           <= slot_len_r[idx_r];
            slot_valid_r[idx_r] <= 1'b0;
            state_r             <= ST_DELIV;
          end else if (idx_r == LastIdx) begin
            state_r <= ST_ACK;
          end else begin
            idx_r <= idx_r + IdxW'(1);
          end
        end

        ST_ACK: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= rrca_pkg::KIND_ACK;
            out_seq_r   <= our_seq_r;
            out_len_r   <= '0;
            out_ack_r   <= next_exp_r;
            out_syn_r   <= syn_r;
            out_fin_r   <= done_r;
            out_dup_r   <= dup_r;
            out_ovf_r   <= ovf_r;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Slot contents carry no reset; they are only read while the slot is valid.
  always_ff @(posedge clk) begin
    if (state_r == ST_STORE) begin
      if (hit_found_r) begin
        slot_len_r[hit_idx_r] <= seg_len_r;
      end else if (free_found_r) begin
        slot_seq_r[free_idx_r] <= seg_seq_r;
        slot_len_r[free_idx_r] <= seg_len_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_seq           = out_seq_r;
  assign out_len           = out_len_r;
  assign out_ack_number    = out_ack_r;
  assign out_syn_out       = out_syn_r;
  assign out_fin_out       = out_fin_r;
  assign out_dup_flag      = out_dup_r;
  assign out_overflow_flag = out_ovf_r;
  assign out_last          = out_last_r;

`ifndef ASSERT_OFF
  a_accept_classifies: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> state_r == ST_CLASS)
    else $error("accepted segment was not classified next cycle");

  a_last_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_kind_r == rrca_pkg::KIND_ACK)
    else $error("final beat of a segment is not an acknowledgement");

  a_deliver_connected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == rrca_pkg::KIND_DELIVER |-> connected_r && !out_last_r)
    else $error("delivery beat before handshake or marked last");

  a_done_connected: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> connected_r)
    else $error("connection finished without handshake");

  a_fin_bumps_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> our_seq_r == $past(our_seq_r) + rrca_pkg::SEQ_W'(1))
    else $error("own sequence number not advanced on FIN");
`endif

endmodule
